// ----- sv/mbpu_pkg.sv -----
// Shared types and constants for the 1-bit bitmap pixel unpacker.
`default_nettype none

package mbpu_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned NPIX_W = 4;

  // One pixel-data byte with everything the back end needs to expand it
  typedef struct packed {
    logic [BYTE_W-1:0] data;   // pixel bits, MSB first
    logic [PIX_W-1:0]  col;    // column of the first pixel
    logic [PIX_W-1:0]  yoff;   // height - 1 - row, before the origin is added
    logic [NPIX_W-1:0] npix;   // pixels to emit, 1..8
    logic              done;   // last pixel of this byte ends the image
  } mbpu_entry_t;

endpackage

`default_nettype wire

// ----- sv/mbpu_front.sv -----
// Front end: header parsing, padding skip and per-byte pixel classification.
`default_nettype none

module mbpu_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [7:0]           in_tdata,   // [7:0] data_byte
  input  wire                  in_tuser,   // [0] file_start
  input  wire                  q_full,
  output logic                 q_push,
  output mbpu_pkg::mbpu_entry_t q_entry
);

  // Header byte positions (little-endian, low 16 bits of each field used)
  localparam logic [15:0] POS_OFF_LO = 16'd10;
  localparam logic [15:0] POS_OFF_HI = 16'd11;
  localparam logic [15:0] POS_WID_LO = 16'd18;
  localparam logic [15:0] POS_WID_HI = 16'd19;
  localparam logic [15:0] POS_HGT_LO = 16'd22;
  localparam logic [15:0] POS_HGT_HI = 16'd23;
  localparam logic [15:0] HEADER_END = 16'd26;
  localparam logic [15:0] BYTE_PIX   = 16'd8;

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] off_r, off_nxt;
  logic [15:0] wid_r, wid_nxt;
  logic [15:0] hgt_r, hgt_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        fin_r, fin_nxt;

  logic        accept;
  logic        emit;
  logic [15:0] pos_e, off_e, wid_e, hgt_e, col_e, row_e;
  logic [1:0]  pad_e;
  logic        fin_e;
  logic [15:0] data_start;
  logic [15:0] remain;
  logic        row_end;
  logic [16:0] row_inc;
  logic [15:0] wid_round;
  logic [1:0]  pad_calc;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Classify the byte and work out the next parse state
  always_comb begin
    // file start clears the parse state and takes this byte as byte 0
    pos_e = in_tuser ? '0 : pos_r;
    off_e = in_tuser ? '0 : off_r;
    wid_e = in_tuser ? '0 : wid_r;
    hgt_e = in_tuser ? '0 : hgt_r;
    col_e = in_tuser ? '0 : col_r;
    row_e = in_tuser ? '0 : row_r;
    pad_e = in_tuser ? '0 : pad_r;
    fin_e = in_tuser ? 1'b0 : fin_r;

    // header capture
    if (pos_e == POS_OFF_LO) off_e = {off_e[15:8], in_tdata};
    if (pos_e == POS_OFF_HI) off_e = {in_tdata, off_e[7:0]};
    if (pos_e == POS_WID_LO) wid_e = {wid_e[15:8], in_tdata};
    if (pos_e == POS_WID_HI) wid_e = {in_tdata, wid_e[7:0]};
    if (pos_e == POS_HGT_LO) hgt_e = {hgt_e[15:8], in_tdata};
    if (pos_e == POS_HGT_HI) hgt_e = {in_tdata, hgt_e[7:0]};

    data_start = (off_e < HEADER_END) ? HEADER_END : off_e;
    remain     = wid_e - col_e;
    row_end    = (remain <= BYTE_PIX);
    row_inc    = {1'b0, row_e} + 17'd1;
    // rows are padded to 4 bytes: pad = -ceil(width/8) mod 4
    wid_round  = wid_e + 16'd7;
    pad_calc   = 2'd0 - wid_round[4:3];

    pos_nxt = pos_e;
    off_nxt = off_e;
    wid_nxt = wid_e;
    hgt_nxt = hgt_e;
    col_nxt = col_e;
    row_nxt = row_e;
    pad_nxt = pad_e;
    fin_nxt = fin_e;
    emit    = 1'b0;

    if (!fin_e) begin
      if (pos_e < data_start) begin
        // position never passes the data start, so no saturation needed
        pos_nxt = pos_e + 16'd1;
      end else if (wid_e == '0 || hgt_e == '0) begin
        fin_nxt = 1'b1;
      end else if (pad_e != '0) begin
        pad_nxt = pad_e - 2'd1;
      end else begin
        emit = 1'b1;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_inc[15:0];
          pad_nxt = pad_calc;
          fin_nxt = (row_inc >= {1'b0, hgt_e});
        end else begin
          col_nxt = col_e + BYTE_PIX;
        end
      end
    end
  end

  // Queue entry for a pixel byte
  always_comb begin
    q_push       = accept && emit;
    q_entry.data = in_tdata;
    q_entry.col  = col_e;
    q_entry.yoff = hgt_e - 16'd1 - row_e;
    q_entry.npix = row_end ? remain[mbpu_pkg::NPIX_W-1:0] : BYTE_PIX[mbpu_pkg::NPIX_W-1:0];
    q_entry.done = row_end && (row_inc >= {1'b0, hgt_e});
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      off_r <= '0;
      wid_r <= '0;
      hgt_r <= '0;
      col_r <= '0;
      row_r <= '0;
      pad_r <= '0;
      fin_r <= 1'b1;
    end else if (accept) begin
      pos_r <= pos_nxt;
      off_r <= off_nxt;
      wid_r <= wid_nxt;
      hgt_r <= hgt_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      pad_r <= pad_nxt;
      fin_r <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mbpu_queue.sv -----
// Small queue of classified pixel bytes between front and back end.
`default_nettype none

module mbpu_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  mbpu_pkg::mbpu_entry_t  push_entry,
  output logic                  full,
  output logic                  not_empty,
  input  wire                   pop,
  output mbpu_pkg::mbpu_entry_t  pop_entry
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mbpu_pkg::mbpu_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// ----- sv/mbpu_back.sv -----
// Back end: expands a pixel byte into one coordinate result per cycle while out_tready does not stall the output.
`default_nettype none

module mbpu_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [15:0]           origin_x,
  input  wire  [15:0]           origin_y,
  input  wire                   q_valid,
  input  mbpu_pkg::mbpu_entry_t  q_entry,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [39:0]           out_tdata,  // [15:0] pixel_x, [31:16] pixel_y, [32] pixel_on
  output logic                  out_tlast,  // last_of_byte
  output logic                  out_tuser   // [0] image_done
);

  localparam int unsigned PW = mbpu_pkg::PIX_W;
  localparam int unsigned NW = mbpu_pkg::NPIX_W;

  // Working byte
  logic                  w_valid_r;
  logic [7:0]            w_data_r;
  logic [COORD_BITS-1:0] w_col_r;
  logic [COORD_BITS-1:0] w_yoff_r;
  logic [NW-1:0]         w_rem_r;
  logic                  w_done_r;

  // Output register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] px_r;
  logic [COORD_BITS-1:0] py_r;
  logic                  on_r;
  logic                  last_r;
  logic                  done_r;

  logic advance;
  logic w_last;

  assign advance = w_valid_r && (!out_valid_r || out_tready);
  assign w_last  = (w_rem_r == NW'(1));
  assign q_pop   = q_valid && (!w_valid_r || (advance && w_last));

  // Working byte: load from queue, or shift one pixel out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r <= 1'b0;
    end else if (q_pop) begin
      w_valid_r <= 1'b1;
      w_data_r  <= q_entry.data;
      w_col_r   <= q_entry.col[COORD_BITS-1:0];
      w_yoff_r  <= q_entry.yoff[COORD_BITS-1:0];
      w_rem_r   <= q_entry.npix;
      w_done_r  <= q_entry.done;
    end else if (advance) begin
      w_data_r <= {w_data_r[6:0], 1'b0};
      w_col_r  <= w_col_r + COORD_BITS'(1);
      w_rem_r  <= w_rem_r - NW'(1);
      if (w_last) w_valid_r <= 1'b0;
    end
  end

  // Output register: coordinates wrap at COORD_BITS
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      px_r        <= origin_x[COORD_BITS-1:0] + w_col_r;
      py_r        <= origin_y[COORD_BITS-1:0] + w_yoff_r;
      on_r        <= w_data_r[7];
      last_r      <= w_last;
      done_r      <= w_last && w_done_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, on_r, PW'(py_r), PW'(px_r)};
  assign out_tlast  = last_r;
  assign out_tuser  = done_r;

`ifndef NO_ASSERTIONS
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    w_valid_r |-> (w_rem_r != '0) && (w_rem_r <= NW'(8)))
    else $error("working byte holds a bad pixel count");
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> last_r)
    else $error("image end not on the last pixel of a byte");
`endif

endmodule

`default_nettype wire

// ----- sv/mono_bmp_pixel_unpacker.sv -----
// Path: a byte's first pixel is registered in the queue, then in the back end's
// working byte, then in its output register. Header, padding and ignored bytes
// are taken whenever the queue is not full; pixel bytes are paced by the back end
// emitting one pixel per cycle while out_tready allows; the queue lets input run ahead.
// Reset (rst_n, synchronous, active low): origins 0, queue empty, parser idle
// until a byte with file_start set.
`default_nettype none

module mono_bmp_pixel_unpacker #(
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tuser,   // [0] file_start
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [15:0] pixel_x, [31:16] pixel_y, [32] pixel_on
  output logic        out_tlast,  // last_of_byte
  output logic        out_tuser,  // [0] image_done
  input  wire         cfg_we,
  input  wire         cfg_addr,
  input  wire  [15:0] cfg_wdata
);

  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  logic [15:0] origin_x_r;
  logic [15:0] origin_y_r;

  logic                  q_full;
  logic                  q_push;
  logic                  q_valid;
  logic                  q_pop;
  mbpu_pkg::mbpu_entry_t push_entry;
  mbpu_pkg::mbpu_entry_t pop_entry;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ORIGIN_X: origin_x_r <= cfg_wdata;
        CFG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mbpu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  mbpu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .not_empty  (q_valid),
    .pop        (q_pop),
    .pop_entry  (pop_entry)
  );

  mbpu_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .origin_x   (origin_x_r),
    .origin_y   (origin_y_r),
    .q_valid    (q_valid),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
